[hw/rtl/afsd_pkg.sv]
// Shared constants, types and the pseudo-noise sequence for the frame
// synchronizer and derandomizer. No dependencies.
package afsd_pkg;

  // Sequence length and interleave limit of the frame format.
  localparam int unsigned TableLen      = 255;
  localparam int unsigned MaxInterleave = 8;

  // Field and counter widths.
  localparam int unsigned MarkerW    = 32;
  localparam int unsigned ErrW       = 6;
  localparam int unsigned BlockW     = 8;
  localparam int unsigned DepthCfgW  = 4;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned BitCntW    = 4;
  localparam int unsigned ByteCntW   = 11;
  localparam int unsigned PosW       = 8;
  localparam int unsigned DepthW     = $clog2(MaxInterleave + 1);
  localparam int unsigned FrameLenW  = BlockW + DepthW;
  localparam int unsigned CmpW       = (FrameLenW > ByteCntW) ? FrameLenW : ByteCntW;

  // Configuration port layout.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSyncMarker     = 3'd0,
    CfgMaxBitErrors   = 3'd1,
    CfgDerandomiseOn  = 3'd2,
    CfgBlockBytes     = 3'd3,
    CfgInterleaveDepth = 3'd4
  } cfg_idx_e;

  // Register values after reset.
  localparam logic [MarkerW-1:0]   SyncMarkerRst   = 32'h1ACF_FC1D;
  localparam logic [ErrW-1:0]      MaxBitErrorsRst = '0;
  localparam logic                 DerandOnRst     = 1'b1;
  localparam logic [BlockW-1:0]    BlockBytesRst   = 8'd255;
  localparam logic [DepthCfgW-1:0] DepthRst        = 4'd1;

  // One delivered result beat.
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             frame_first;
    logic             frame_last;
  } result_t;

  // Pseudo-noise byte sequence, first byte at index zero.
  localparam logic [ByteW-1:0] PnSeq [TableLen] = '{
    8'd255, 8'd72, 8'd14, 8'd192, 8'd154, 8'd13, 8'd112, 8'd188,
    8'd142, 8'd44, 8'd147, 8'd173, 8'd167, 8'd183, 8'd70, 8'd206,
    8'd90, 8'd151, 8'd125, 8'd204, 8'd50, 8'd162, 8'd191, 8'd62,
    8'd10, 8'd16, 8'd241, 8'd136, 8'd148, 8'd205, 8'd234, 8'd177,
    8'd254, 8'd144, 8'd29, 8'd129, 8'd52, 8'd26, 8'd225, 8'd121,
    8'd28, 8'd89, 8'd39, 8'd91, 8'd79, 8'd110, 8'd141, 8'd156,
    8'd181, 8'd46, 8'd251, 8'd152, 8'd101, 8'd69, 8'd126, 8'd124,
    8'd20, 8'd33, 8'd227, 8'd17, 8'd41, 8'd155, 8'd213, 8'd99,
    8'd253, 8'd32, 8'd59, 8'd2, 8'd104, 8'd53, 8'd194, 8'd242,
    8'd56, 8'd178, 8'd78, 8'd182, 8'd158, 8'd221, 8'd27, 8'd57,
    8'd106, 8'd93, 8'd247, 8'd48, 8'd202, 8'd138, 8'd252, 8'd248,
    8'd40, 8'd67, 8'd198, 8'd34, 8'd83, 8'd55, 8'd170, 8'd199,
    8'd250, 8'd64, 8'd118, 8'd4, 8'd208, 8'd107, 8'd133, 8'd228,
    8'd113, 8'd100, 8'd157, 8'd109, 8'd61, 8'd186, 8'd54, 8'd114,
    8'd212, 8'd187, 8'd238, 8'd97, 8'd149, 8'd21, 8'd249, 8'd240,
    8'd80, 8'd135, 8'd140, 8'd68, 8'd166, 8'd111, 8'd85, 8'd143,
    8'd244, 8'd128, 8'd236, 8'd9, 8'd160, 8'd215, 8'd11, 8'd200,
    8'd226, 8'd201, 8'd58, 8'd218, 8'd123, 8'd116, 8'd108, 8'd229,
    8'd169, 8'd119, 8'd220, 8'd195, 8'd42, 8'd43, 8'd243, 8'd224,
    8'd161, 8'd15, 8'd24, 8'd137, 8'd76, 8'd222, 8'd171, 8'd31,
    8'd233, 8'd1, 8'd216, 8'd19, 8'd65, 8'd174, 8'd23, 8'd145,
    8'd197, 8'd146, 8'd117, 8'd180, 8'd246, 8'd232, 8'd217, 8'd203,
    8'd82, 8'd239, 8'd185, 8'd134, 8'd84, 8'd87, 8'd231, 8'd193,
    8'd66, 8'd30, 8'd49, 8'd18, 8'd153, 8'd189, 8'd86, 8'd63,
    8'd210, 8'd3, 8'd176, 8'd38, 8'd131, 8'd92, 8'd47, 8'd35,
    8'd139, 8'd36, 8'd235, 8'd105, 8'd237, 8'd209, 8'd179, 8'd150,
    8'd165, 8'd223, 8'd115, 8'd12, 8'd168, 8'd175, 8'd207, 8'd130,
    8'd132, 8'd60, 8'd98, 8'd37, 8'd51, 8'd122, 8'd172, 8'd127,
    8'd164, 8'd7, 8'd96, 8'd77, 8'd6, 8'd184, 8'd94, 8'd71,
    8'd22, 8'd73, 8'd214, 8'd211, 8'd219, 8'd163, 8'd103, 8'd45,
    8'd75, 8'd190, 8'd230, 8'd25, 8'd81, 8'd95, 8'd159, 8'd5,
    8'd8, 8'd120, 8'd196, 8'd74, 8'd102, 8'd245, 8'd88
  };

endpackage

[hw/rtl/afsd_bit_if.sv]
// Received-bit channel: valid/ready handshake with one hard bit per beat.
// Does not depend on afsd_pkg.
interface afsd_bit_if;

  logic valid;
  logic ready;
  logic rx_bit;

  modport source (output valid, output rx_bit, input ready);
  modport sink (input valid, input rx_bit, output ready);

endinterface

[hw/rtl/afsd_byte_if.sv]
// Frame byte channel: valid/ready handshake with one byte and frame flags per beat.
// Depends on afsd_pkg for the byte width.
interface afsd_byte_if;
  import afsd_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             frame_first;
  logic             frame_last;

  modport source (output valid, output data_byte, output frame_first, output frame_last,
                  input ready);
  modport sink (input valid, input data_byte, input frame_first, input frame_last,
                output ready);

endinterface

[hw/rtl/afsd_cfg_if.sv]
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on afsd_pkg for the index and data widths.
interface afsd_cfg_if;
  import afsd_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);

endinterface

[hw/rtl/afsd_marker_match.sv]
// Sync marker comparator: counts differing bits with an adder tree and
// checks the count against the tolerance. Depends on afsd_pkg.
module afsd_marker_match (
  input  logic [afsd_pkg::MarkerW-1:0] word_i,
  input  logic [afsd_pkg::MarkerW-1:0] marker_i,
  input  logic [afsd_pkg::ErrW-1:0]    max_err_i,
  output logic                         match_o
);
  import afsd_pkg::*;

  logic [MarkerW-1:0] diff;
  logic [MarkerW-1:0] sum2;
  logic [MarkerW-1:0] sum4;
  logic [MarkerW-1:0] sum8;
  logic [ErrW-1:0]    err_cnt;

  // Pairwise, nibble and byte partial sums, then add the four byte counts.
  always_comb begin
    diff = word_i ^ marker_i;
    sum2 = ((diff >> 1) & 32'h5555_5555) + (diff & 32'h5555_5555);
    sum4 = ((sum2 >> 2) & 32'h3333_3333) + (sum2 & 32'h3333_3333);
    sum8 = ((sum4 >> 4) & 32'h0F0F_0F0F) + (sum4 & 32'h0F0F_0F0F);
    err_cnt = ErrW'(sum8[31:24]) + ErrW'(sum8[23:16]) + ErrW'(sum8[15:8]) + ErrW'(sum8[7:0]);
  end

  assign match_o = (err_cnt <= max_err_i);

endmodule

[hw/rtl/asm_frame_sync_derandomizer_core.sv]
// Frame synchronizer with pseudo-noise derandomizer, one received bit per beat.
// An accepted bit is held in the input register and processed from there; the byte it
// completes is loaded into the result register and offered from that register.
// Throughput: one bit per cycle while the result slot is free or being taken; one byte per eight framed bits.
// Reset (rst_ni low, asynchronous) clears the valid flags and framing state, enters marker hunting
// and restores the register defaults. Depends on afsd_pkg, interfaces, marker match.
module asm_frame_sync_derandomizer_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  afsd_cfg_if.sink     cfg_i,
  afsd_bit_if.sink     bit_i,
  afsd_byte_if.source  byte_o
);
  import afsd_pkg::*;

  // Configuration registers.
  logic [MarkerW-1:0]   sync_marker_q;
  logic [ErrW-1:0]      max_bit_errors_q;
  logic                 derand_on_q;
  logic [BlockW-1:0]    block_bytes_q;
  logic [DepthCfgW-1:0] depth_q;

  // Input register.
  logic in_valid_q;
  logic in_bit_q;

  // Framing state.
  logic [MarkerW-1:0]  shifter_q, shifter_d;
  logic                in_frame_q, in_frame_d;
  logic [BitCntW-1:0]  bits_q, bits_d;
  logic [ByteCntW-1:0] bytes_done_q, bytes_done_d;
  logic [PosW-1:0]     pos_q, pos_d;

  // Result register.
  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;

  logic                advance;
  logic [MarkerW-1:0]  shift_next;
  logic                match;
  logic [BitCntW-1:0]  bits_next;
  logic [ByteCntW-1:0] bytes_next;
  logic [PosW:0]       pos_next;
  logic [DepthW-1:0]   depth_sat;
  logic [FrameLenW-1:0] frame_len;
  logic [ByteW-1:0]    pn_byte;
  logic                emit;

  assign cfg_i.ready = 1'b1;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_marker_q    <= SyncMarkerRst;
      max_bit_errors_q <= MaxBitErrorsRst;
      derand_on_q      <= DerandOnRst;
      block_bytes_q    <= BlockBytesRst;
      depth_q          <= DepthRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgSyncMarker:      sync_marker_q    <= cfg_i.data[MarkerW-1:0];
        CfgMaxBitErrors:    max_bit_errors_q <= cfg_i.data[ErrW-1:0];
        CfgDerandomiseOn:   derand_on_q      <= cfg_i.data[0];
        CfgBlockBytes:      block_bytes_q    <= cfg_i.data[BlockW-1:0];
        CfgInterleaveDepth: depth_q          <= cfg_i.data[DepthCfgW-1:0];
        default: ;
      endcase
    end
  end

  // The processing stage moves when it holds a bit and the result slot is free.
  assign advance     = in_valid_q && (!out_valid_q || byte_o.ready);
  assign bit_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (bit_i.ready) begin
      in_valid_q <= bit_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bit_i.ready && bit_i.valid) begin
      in_bit_q <= bit_i.rx_bit;
    end
  end

  assign shift_next = {shifter_q[MarkerW-2:0], in_bit_q};

  afsd_marker_match u_marker_match (
    .word_i    (shift_next),
    .marker_i  (sync_marker_q),
    .max_err_i (max_bit_errors_q),
    .match_o   (match)
  );

  // Frame length, table lookup and next counter values for the byte under assembly.
  always_comb begin
    if (int'(depth_q) > MaxInterleave) begin
      depth_sat = DepthW'(MaxInterleave);
    end else begin
      depth_sat = DepthW'(depth_q);
    end
    frame_len = FrameLenW'(block_bytes_q) * FrameLenW'(depth_sat);
    if (derand_on_q && (pos_q < PosW'(TableLen))) begin
      pn_byte = PnSeq[pos_q];
    end else begin
      pn_byte = '0;
    end
    bits_next  = bits_q + 1'b1;
    bytes_next = bytes_done_q + 1'b1;
    pos_next   = {1'b0, pos_q} + 1'b1;
    if ((pos_next >= {1'b0, block_bytes_q}) || (pos_next >= (PosW + 1)'(TableLen))) begin
      pos_next = '0;
    end
  end

  // Per-bit state update: hunt for the marker or assemble a byte.
  always_comb begin
    shifter_d    = shifter_q;
    in_frame_d   = in_frame_q;
    bits_d       = bits_q;
    bytes_done_d = bytes_done_q;
    pos_d        = pos_q;
    emit         = 1'b0;
    out_d.data_byte   = shift_next[ByteW-1:0] ^ pn_byte;
    out_d.frame_first = (bytes_done_q == '0);
    out_d.frame_last  = 1'b0;
    if (advance) begin
      if (!in_frame_q) begin
        if (match) begin
          in_frame_d   = 1'b1;
          shifter_d    = '0;
          bits_d       = '0;
          bytes_done_d = '0;
          pos_d        = '0;
        end else begin
          shifter_d = shift_next;
        end
      end else if (bits_next < BitCntW'(ByteW)) begin
        shifter_d = shift_next;
        bits_d    = bits_next;
      end else begin
        emit         = 1'b1;
        shifter_d    = '0;
        bits_d       = '0;
        bytes_done_d = bytes_next;
        pos_d        = pos_next[PosW-1:0];
        if (CmpW'(bytes_next) >= CmpW'(frame_len)) begin
          out_d.frame_last = 1'b1;
          in_frame_d       = 1'b0;
          bytes_done_d     = '0;
          pos_d            = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shifter_q    <= '0;
      in_frame_q   <= 1'b0;
      bits_q       <= '0;
      bytes_done_q <= '0;
      pos_q        <= '0;
    end else begin
      shifter_q    <= shifter_d;
      in_frame_q   <= in_frame_d;
      bits_q       <= bits_d;
      bytes_done_q <= bytes_done_d;
      pos_q        <= pos_d;
    end
  end

  // Result register: loaded on a finished byte, cleared when its beat is taken.
  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (byte_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign byte_o.valid       = out_valid_q;
  assign byte_o.data_byte   = out_q.data_byte;
  assign byte_o.frame_first = out_q.frame_first;
  assign byte_o.frame_last  = out_q.frame_last;

endmodule
